@@ rtl/clbt_pkg.sv @@
package clbt_pkg;

    // Table geometry
    localparam int NUM_CORES = 16;
    localparam int ID_BITS   = 8;

    // Fixed field widths
    localparam int MASK_W     = 16;
    localparam int MAXC_W     = 5;
    localparam int CNT_OUT_W  = 5;
    localparam int KIND_W     = 4;
    localparam int CPU_W      = 4;
    localparam int REQ_ID_W   = 8;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Internal count wide enough for every core
    localparam int CNT_NEED = $clog2(NUM_CORES + 1);
    localparam int CNT_W    = (CNT_NEED > CNT_OUT_W) ? CNT_NEED : CNT_OUT_W;

    localparam logic [ID_BITS-1:0] NOBODY = '0;

    localparam logic [ST_W-1:0] ST_DISABLED = 2'd0;
    localparam logic [ST_W-1:0] ST_BUSY     = 2'd1;
    localparam logic [ST_W-1:0] ST_LENT     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_MASK       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLIC_AFTER_EXIT = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        K_CLAIM        = 4'd0,
        K_RELEASE      = 4'd1,
        K_LEND         = 4'd2,
        K_RECLAIM      = 4'd3,
        K_ACQUIRE      = 4'd4,
        K_CHK_BORROWED = 4'd5,
        K_CHK_CLAIMED  = 4'd6,
        K_COLLECT      = 4'd7,
        K_RETURN       = 4'd8,
        K_RECOVER      = 4'd9
    } t_kind;

    // Request item as it arrives on the input channel
    typedef struct packed {
        logic [KIND_W-1:0]   req_type;
        logic [REQ_ID_W-1:0] requester;
        logic [CPU_W-1:0]    cpu;
        logic                force_req;
        logic [MAXC_W-1:0]   max_count;
        logic [MASK_W-1:0]   aff_mask;
    } t_req_item;

    // Result item on the output channel
    typedef struct packed {
        logic                 granted;
        logic [CNT_OUT_W-1:0] count;
        logic [MASK_W-1:0]    mask_out;
    } t_rsp_item;

    // Configuration write
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg_item;

    // Request held for the whole walk along the cells
    typedef struct packed {
        t_kind             kind;
        logic [ID_BITS-1:0] me;
        logic [CPU_W-1:0]  cpu;
        logic              force_req;
        logic              unlim;
    } t_req;

    // Per-cell control, fixed for one walk
    typedef struct packed {
        logic              sel;
        logic              in_mask;
        logic              pub;
        logic [MASK_W-1:0] core_bit;
    } t_ctl;

    // Token handed from cell to cell
    typedef struct packed {
        logic              pass;
        logic [MAXC_W-1:0] left;
        logic [CNT_W-1:0]  count;
        logic [MASK_W-1:0] mask;
        logic              granted;
    } t_tok;

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] lim;
        lim = CNT_W'({CNT_OUT_W{1'b1}});
        return (n > lim) ? {CNT_OUT_W{1'b1}} : n[CNT_OUT_W-1:0];
    endfunction

endpackage

@@ rtl/clbt_if.sv @@
interface clbt_req_if import clbt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clbt_rsp_if import clbt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clbt_cfg_if import clbt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/clbt_cell.sv @@
module clbt_cell import clbt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_ctl i_ctl,
    input  logic i_tok_valid,
    input  t_tok i_tok,
    output logic o_tok_valid,
    output t_tok o_tok
);

    logic [ID_BITS-1:0] r_owner, n_owner;
    logic [ID_BITS-1:0] r_guest, n_guest;
    logic [ST_W-1:0]    r_state, n_state;
    logic               r_tok_valid;
    t_tok               r_tok, n_tok;
    logic               idle, own;

    always_comb begin
        n_owner = r_owner;
        n_guest = r_guest;
        n_state = r_state;
        n_tok   = i_tok;
        idle    = (r_state == ST_LENT) && (r_guest == NOBODY);
        own     = (r_owner == i_req.me);
        if (i_tok_valid) begin
            case (i_req.kind)
                K_CLAIM: begin
                    if (i_ctl.sel && r_owner == NOBODY) begin
                        n_owner = i_req.me;
                        n_state = ST_BUSY;
                        if (r_guest == NOBODY) begin
                            n_guest = i_req.me;
                        end
                        n_tok.granted = 1'b1;
                    end
                end
                K_RELEASE: begin
                    if (own) begin
                        n_owner = NOBODY;
                        if (r_guest == i_req.me) begin
                            n_guest = NOBODY;
                        end
                        n_state = i_ctl.pub ? ST_LENT : ST_DISABLED;
                    end else if (r_guest == i_req.me) begin
                        n_guest = NOBODY;
                    end
                end
                K_LEND: begin
                    if (i_ctl.sel) begin
                        if (own) begin
                            n_state = ST_LENT;
                        end
                        if (r_guest == i_req.me) begin
                            n_guest = NOBODY;
                        end
                    end
                end
                K_RECLAIM: begin
                    if (i_ctl.sel && own) begin
                        n_state = ST_BUSY;
                        if (r_guest == NOBODY) begin
                            n_guest = i_req.me;
                        end
                    end
                end
                K_ACQUIRE: begin
                    if (i_ctl.sel) begin
                        if (own) begin
                            n_state = ST_BUSY;
                            n_tok.granted = 1'b1;
                        end else if (idle) begin
                            n_guest = i_req.me;
                            n_tok.granted = 1'b1;
                        end else if (i_req.force_req && r_guest == r_owner) begin
                            n_guest = i_req.me;
                            n_tok.granted = 1'b1;
                        end
                    end
                end
                K_CHK_BORROWED: begin
                    if (i_ctl.sel) begin
                        if (!own) begin
                            n_tok.granted = 1'b1;
                        end else if (r_guest == NOBODY) begin
                            n_guest = i_req.me;
                            n_tok.granted = 1'b1;
                        end else begin
                            n_tok.granted = (r_guest == i_req.me);
                        end
                    end
                end
                K_CHK_CLAIMED: begin
                    if (i_ctl.sel) begin
                        n_tok.granted = (r_state == ST_DISABLED) ||
                                        (!own && r_state == ST_BUSY);
                    end
                end
                K_COLLECT: begin
                    if ((i_tok.pass || i_ctl.in_mask) && idle && i_tok.left != '0) begin
                        n_guest     = i_req.me;
                        n_tok.mask  = i_tok.mask | i_ctl.core_bit;
                        n_tok.left  = i_tok.left - MAXC_W'(1);
                        n_tok.count = i_tok.count + CNT_W'(1);
                    end
                end
                K_RETURN: begin
                    if (i_ctl.in_mask && !own && r_state != ST_LENT) begin
                        if (r_guest == i_req.me) begin
                            n_guest = r_owner;
                        end
                        n_tok.count = i_tok.count + CNT_W'(1);
                        n_tok.mask  = i_tok.mask & ~i_ctl.core_bit;
                    end
                end
                K_RECOVER: begin
                    if ((i_req.unlim || i_tok.left != '0) && own && !i_ctl.in_mask) begin
                        n_state     = ST_BUSY;
                        n_tok.mask  = i_tok.mask | i_ctl.core_bit;
                        n_tok.count = i_tok.count + CNT_W'(1);
                        if (!i_req.unlim) begin
                            n_tok.left = i_tok.left - MAXC_W'(1);
                        end
                        if (r_guest == NOBODY) begin
                            n_guest = i_req.me;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner     <= NOBODY;
            r_guest     <= NOBODY;
            r_state     <= ST_DISABLED;
            r_tok_valid <= 1'b0;
        end else begin
            r_owner     <= n_owner;
            r_guest     <= n_guest;
            r_state     <= n_state;
            r_tok_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

endmodule

@@ rtl/cpu_lend_borrow_table_core.sv @@
// Core lend/borrow table. Each core has one cell in a chain that holds its owner id, guest id
// and state (disabled, busy or lent). An accepted request is latched and a token then walks
// the chain one cell per clock, lowest core first; each cell applies the request to its own
// core and hands the running count, limit and mask to its neighbor. Claim, release, lend,
// reclaim, acquire, the checks, return_claimed and recover_some pass through the launch
// register, every cell and the finished-result register into the output register; collect
// walks the chain twice (affine cores first, then all cores) before its result is loaded.
// A request from requester 0, of an unknown type, or naming a core out of range
// is answered with all-zero fields without a walk. One request is in the chain at a time,
// and the input takes the next request as soon as the previous result sits in the output
// register, even if that result is not yet taken. Configuration writes are always accepted
// and must only be issued while no request is open.
module cpu_lend_borrow_table_core import clbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clbt_req_if.sink   i_req_ch,
    clbt_rsp_if.source o_rsp_ch,
    clbt_cfg_if.sink   i_cfg_ch
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_fsm;

    t_fsm              r_fsm;
    t_req              r_req;
    logic [MASK_W-1:0] r_cmask;
    logic [MASK_W-1:0] r_pub_mask;
    logic              r_pae;
    logic              r_launch_v;
    t_tok              r_launch;
    t_rsp_item         r_fin;
    logic              r_out_valid;
    t_rsp_item         r_out;

    // Token chain: entry 0 feeds the first cell, entry NUM_CORES leaves the last one
    logic [NUM_CORES:0] w_tok_v;
    t_tok               w_tok [NUM_CORES+1];
    t_ctl               w_ctl [NUM_CORES];

    t_req_item in_d;
    t_kind     in_kind;
    logic      in_xfer;
    logic      in_single;
    logic      in_bad;
    t_req      in_req;
    t_tok      in_tok;
    t_tok      relaunch;
    logic      out_free;
    logic      chain_done;

    assign in_d    = i_req_ch.data;
    assign in_kind = t_kind'(in_d.req_type);
    assign in_xfer = i_req_ch.valid && i_req_ch.ready;

    // Decode the incoming request and build the first token
    always_comb begin
        in_single = (in_kind == K_CLAIM) || (in_kind == K_LEND) || (in_kind == K_RECLAIM) ||
                    (in_kind == K_ACQUIRE) || (in_kind == K_CHK_BORROWED) ||
                    (in_kind == K_CHK_CLAIMED);
        in_req.kind      = in_kind;
        in_req.me        = ID_BITS'(in_d.requester);
        in_req.cpu       = in_d.cpu;
        in_req.force_req = in_d.force_req;
        in_req.unlim     = (in_d.max_count == '0);
        in_bad = (in_req.me == NOBODY) || (in_d.req_type > K_RECOVER) ||
                 (in_single && int'(in_d.cpu) >= NUM_CORES);

        in_tok.pass    = 1'b0;
        in_tok.left    = in_d.max_count;
        in_tok.count   = '0;
        in_tok.mask    = (in_kind == K_RETURN || in_kind == K_RECOVER) ? in_d.aff_mask : '0;
        in_tok.granted = !(in_kind == K_CLAIM || in_kind == K_ACQUIRE ||
                           in_kind == K_CHK_BORROWED || in_kind == K_CHK_CLAIMED);
    end

    // Token for the second collect pass: the first pass result, marked as pass two
    always_comb begin
        relaunch      = w_tok[NUM_CORES];
        relaunch.pass = 1'b1;
    end

    assign i_req_ch.ready = (r_fsm == S_IDLE);
    assign out_free       = !r_out_valid || o_rsp_ch.ready;
    assign chain_done     = w_tok_v[NUM_CORES];

    // Sequencer: launch, re-launch for the second collect pass, finish, hand off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm      <= S_IDLE;
            r_launch_v <= 1'b0;
        end else begin
            r_launch_v <= 1'b0;
            case (r_fsm)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (in_bad) begin
                            r_fsm <= S_FIN;
                        end else begin
                            r_launch_v <= 1'b1;
                            r_fsm      <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (chain_done) begin
                        if (r_req.kind == K_COLLECT && !w_tok[NUM_CORES].pass) begin
                            r_launch_v <= 1'b1;
                        end else begin
                            r_fsm <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_fsm <= S_IDLE;
                    end
                end
                default: begin
                    r_fsm <= S_IDLE;
                end
            endcase
        end
    end

    // Request, launch token and finished result: payload only
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req    <= in_req;
            r_cmask  <= in_d.aff_mask;
            r_launch <= in_tok;
            r_fin    <= '0;
        end else if (r_fsm == S_RUN && chain_done) begin
            r_launch <= relaunch;
            r_fin    <= '{granted:  w_tok[NUM_CORES].granted,
                          count:    sat_count(w_tok[NUM_CORES].count),
                          mask_out: w_tok[NUM_CORES].mask};
        end
    end

    // Output register: load the finished result when the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_fsm == S_FIN && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fsm == S_FIN && out_free) begin
            r_out <= r_fin;
        end
    end

    assign o_rsp_ch.valid = r_out_valid;
    assign o_rsp_ch.data  = r_out;

    // Configuration registers
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pub_mask <= '0;
            r_pae      <= 1'b0;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.data.index)
                REG_PUBLIC_MASK:       r_pub_mask <= i_cfg_ch.data.value[MASK_W-1:0];
                REG_PUBLIC_AFTER_EXIT: r_pae      <= i_cfg_ch.data.value[0];
                default: begin
                end
            endcase
        end
    end

    // Cell chain
    assign w_tok_v[0] = r_launch_v;
    assign w_tok[0]   = r_launch;

    for (genvar k = 0; k < NUM_CORES; k++) begin : g_cell
        assign w_ctl[k].sel = (int'(r_req.cpu) == k);
        if (k < MASK_W) begin : g_masked
            assign w_ctl[k].in_mask  = r_cmask[k];
            assign w_ctl[k].pub      = r_pae || r_pub_mask[k];
            assign w_ctl[k].core_bit = MASK_W'(1) << k;
        end else begin : g_unmasked
            // Cores beyond the mask width have no bit in any mask
            assign w_ctl[k].in_mask  = 1'b0;
            assign w_ctl[k].pub      = r_pae;
            assign w_ctl[k].core_bit = '0;
        end

        clbt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_req       (r_req),
            .i_ctl       (w_ctl[k]),
            .i_tok_valid (w_tok_v[k]),
            .i_tok       (w_tok[k]),
            .o_tok_valid (w_tok_v[k+1]),
            .o_tok       (w_tok[k+1])
        );
    end

`ifndef NO_ASSERTIONS
    // Only one request token may be in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("more than one token in the cell chain");

    // No token outside a running walk
    a_token_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm != S_RUN) |-> (w_tok_v == '0))
        else $error("token in the chain while no walk runs");

    // A good request starts a walk in the next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !in_bad) |=> (r_fsm == S_RUN && w_tok_v[0]))
        else $error("accepted request did not launch a token");

    // A reported count never exceeds the number of cores
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_ch.valid |-> (int'(o_rsp_ch.data.count) <= NUM_CORES))
        else $error("result count above the number of cores");
`endif

endmodule
